// File: design/dlsc_pkg.sv
// Shared types, codes and character constants of the lexical scanner.
package dlsc_pkg;

	// Position counters
	localparam int POS_WIDTH_DEF = 16;
	localparam int OUT_POS_W     = 16;

	// Most results one text byte can cause
	localparam int MAX_RES   = 4;
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);
	localparam int RES_IDX_W = $clog2(MAX_RES);

	// Token kinds
	typedef enum logic [3:0] {
		KIND_IDENT     = 4'd0,
		KIND_NUMBER    = 4'd1,
		KIND_STRING    = 4'd2,
		KIND_LPAREN    = 4'd3,
		KIND_RPAREN    = 4'd4,
		KIND_LBRACKET  = 4'd5,
		KIND_RBRACKET  = 4'd6,
		KIND_DOT       = 4'd7,
		KIND_COMMA     = 4'd8,
		KIND_SEMICOLON = 4'd9,
		KIND_AT        = 4'd10,
		KIND_ASSIGN    = 4'd11,
		KIND_EQUAL     = 4'd12,
		KIND_BAD_CHAR  = 4'd13,
		KIND_UNTERM    = 4'd14,
		KIND_END       = 4'd15
	} kind_t;

	// Scanner modes
	typedef enum logic [3:0] {
		MODE_IDLE    = 4'd0,
		MODE_IDENT   = 4'd1,
		MODE_INT     = 4'd2,
		MODE_FRAC    = 4'd3,
		MODE_STR     = 4'd4,
		MODE_ESC     = 4'd5,
		MODE_MINUS   = 4'd6,
		MODE_EQ      = 4'd7,
		MODE_SLASH   = 4'd8,
		MODE_COMMENT = 4'd9
	} mode_t;

	// Characters
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_NL         = 8'h0a;
	localparam logic [7:0] CH_CR         = 8'h0d;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_HASH       = 8'h23;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_COMMA      = 8'h2c;
	localparam logic [7:0] CH_MINUS      = 8'h2d;
	localparam logic [7:0] CH_DOT        = 8'h2e;
	localparam logic [7:0] CH_SLASH      = 8'h2f;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;
	localparam logic [7:0] CH_SEMICOLON  = 8'h3b;
	localparam logic [7:0] CH_EQ         = 8'h3d;
	localparam logic [7:0] CH_AT         = 8'h40;
	localparam logic [7:0] CH_UPPER_A    = 8'h41;
	localparam logic [7:0] CH_UPPER_Z    = 8'h5a;
	localparam logic [7:0] CH_LBRACKET   = 8'h5b;
	localparam logic [7:0] CH_BSLASH     = 8'h5c;
	localparam logic [7:0] CH_RBRACKET   = 8'h5d;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_N    = 8'h6e;
	localparam logic [7:0] CH_LOWER_R    = 8'h72;
	localparam logic [7:0] CH_LOWER_T    = 8'h74;
	localparam logic [7:0] CH_LOWER_Z    = 8'h7a;

	// One result item, without the line
	typedef struct packed {
		kind_t                 kind;
		logic                  is_end;
		logic [7:0]            value;
		logic [OUT_POS_W-1:0]  column;
	} res_t;

	// All results of one text byte
	typedef struct packed {
		res_t [MAX_RES-1:0]    res;
		logic [RES_CNT_W-1:0]  count;
		logic [OUT_POS_W-1:0]  line;
	} bundle_t;

endpackage

// File: design/dlsc_if.sv
// Handshake channels of the lexical scanner: text input and token output.
interface dlsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface dlsc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic        is_token_end;
	logic [7:0]  value_byte;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic        last_of_run;

	modport source (
		output valid, output token_kind, output is_token_end, output value_byte,
		output token_line, output token_column, output last_of_run, input ready
	);
	modport sink (
		input valid, input token_kind, input is_token_end, input value_byte,
		input token_line, input token_column, input last_of_run, output ready
	);
endinterface

// File: design/dlsc_decode.sv
// Scanner state registers and the per-byte decision logic.
module dlsc_decode #(
	parameter int POS_WIDTH = dlsc_pkg::POS_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        text_byte,
	output dlsc_pkg::bundle_t bundle
);
	import dlsc_pkg::*;

	mode_t                mode_q, mode_n;
	logic [POS_WIDTH-1:0] line_q, line_n;
	logic [POS_WIDTH-1:0] col_q, col_n;
	logic [POS_WIDTH-1:0] start_q, start_n;
	logic                 do_disp;
	logic [POS_WIDTH-1:0] disp_col;
	logic [RES_CNT_W-1:0] n;
	kind_t                pk;
	logic                 pk_hit;

	function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] x);
		return (x == {POS_WIDTH{1'b1}}) ? x : x + POS_WIDTH'(1);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic ident_start(input logic [7:0] c);
		return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
			((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
			(c == CH_UNDERSCORE) || (c == CH_HASH);
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			CH_LOWER_N: r = CH_NL;
			CH_LOWER_T: r = CH_TAB;
			CH_LOWER_R: r = CH_CR;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic res_t mk_res(input kind_t k, input logic e, input logic [7:0] v,
			input logic [POS_WIDTH-1:0] col);
		res_t r;
		r.kind   = k;
		r.is_end = e;
		r.value  = v;
		r.column = OUT_POS_W'(col);
		return r;
	endfunction

	// Map a punctuation byte to its kind
	always_comb begin
		pk_hit = 1'b1;
		case (text_byte)
			CH_LPAREN:    pk = KIND_LPAREN;
			CH_RPAREN:    pk = KIND_RPAREN;
			CH_LBRACKET:  pk = KIND_LBRACKET;
			CH_RBRACKET:  pk = KIND_RBRACKET;
			CH_DOT:       pk = KIND_DOT;
			CH_COMMA:     pk = KIND_COMMA;
			CH_SEMICOLON: pk = KIND_SEMICOLON;
			CH_AT:        pk = KIND_AT;
			default: begin
				pk     = KIND_IDENT;
				pk_hit = 1'b0;
			end
		endcase
	end

	// Decide results and next state for the current byte
	always_comb begin
		mode_n       = mode_q;
		line_n       = line_q;
		col_n        = col_q;
		start_n      = start_q;
		do_disp      = 1'b0;
		disp_col     = col_q;
		n            = '0;
		bundle.res   = '0;
		bundle.line  = OUT_POS_W'(line_q);

		// finish or extend the token in progress
		case (mode_q)
			MODE_IDENT: begin
				if (ident_start(text_byte) || is_digit(text_byte)) begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_IDENT, 1'b0, text_byte, start_q);
					n = n + 1'b1;
					col_n = sat_inc(col_q);
				end else begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_IDENT, 1'b1, CH_NUL, start_q);
					n = n + 1'b1;
					do_disp = 1'b1;
				end
			end
			MODE_INT, MODE_FRAC: begin
				if (is_digit(text_byte) || (text_byte == CH_DOT && mode_q == MODE_INT)) begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_NUMBER, 1'b0, text_byte, start_q);
					n = n + 1'b1;
					col_n = sat_inc(col_q);
					if (text_byte == CH_DOT) begin
						mode_n = MODE_FRAC;
					end
				end else begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_NUMBER, 1'b1, CH_NUL, start_q);
					n = n + 1'b1;
					do_disp = 1'b1;
				end
			end
			MODE_STR: begin
				if (text_byte == CH_NUL) begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_UNTERM, 1'b1, CH_NUL, start_q);
					n = n + 1'b1;
					do_disp = 1'b1;
				end else if (text_byte == CH_QUOTE) begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_STRING, 1'b1, CH_NUL, start_q);
					n = n + 1'b1;
					col_n = sat_inc(col_q);
					mode_n = MODE_IDLE;
				end else if (text_byte == CH_BSLASH) begin
					col_n = sat_inc(col_q);
					mode_n = MODE_ESC;
				end else begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_STRING, 1'b0, text_byte, start_q);
					n = n + 1'b1;
					col_n = sat_inc(col_q);
				end
			end
			MODE_ESC: begin
				if (text_byte == CH_NUL) begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_STRING, 1'b0, CH_BSLASH, start_q);
					n = n + 1'b1;
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_UNTERM, 1'b1, CH_NUL, start_q);
					n = n + 1'b1;
					do_disp = 1'b1;
				end else begin
					bundle.res[n[RES_IDX_W-1:0]] =
						mk_res(KIND_STRING, 1'b0, unescape(text_byte), start_q);
					n = n + 1'b1;
					col_n = sat_inc(col_q);
					mode_n = MODE_STR;
				end
			end
			MODE_MINUS: begin
				if (is_digit(text_byte)) begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_NUMBER, 1'b0, CH_MINUS, start_q);
					n = n + 1'b1;
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_NUMBER, 1'b0, text_byte, start_q);
					n = n + 1'b1;
					col_n = sat_inc(col_q);
					mode_n = MODE_INT;
				end else begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_BAD_CHAR, 1'b0, CH_MINUS, start_q);
					n = n + 1'b1;
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_BAD_CHAR, 1'b1, CH_NUL, start_q);
					n = n + 1'b1;
					do_disp = 1'b1;
				end
			end
			MODE_EQ: begin
				if (text_byte == CH_EQ) begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_EQUAL, 1'b0, CH_EQ, start_q);
					n = n + 1'b1;
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_EQUAL, 1'b0, CH_EQ, start_q);
					n = n + 1'b1;
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_EQUAL, 1'b1, CH_NUL, start_q);
					n = n + 1'b1;
					col_n = sat_inc(col_q);
					mode_n = MODE_IDLE;
				end else begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_ASSIGN, 1'b0, CH_EQ, start_q);
					n = n + 1'b1;
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_ASSIGN, 1'b1, CH_NUL, start_q);
					n = n + 1'b1;
					do_disp = 1'b1;
				end
			end
			MODE_SLASH: begin
				if (text_byte == CH_SLASH) begin
					mode_n = MODE_COMMENT;
				end else begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_BAD_CHAR, 1'b0, CH_SLASH, start_q);
					n = n + 1'b1;
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_BAD_CHAR, 1'b1, CH_NUL, start_q);
					n = n + 1'b1;
					disp_col = sat_inc(col_q);
					do_disp = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (text_byte == CH_NUL || text_byte == CH_NL) begin
					do_disp = 1'b1;
				end
			end
			default: begin
				do_disp = 1'b1;
			end
		endcase

		// start a new token or skip blanks
		if (do_disp) begin
			mode_n = MODE_IDLE;
			col_n  = disp_col;
			if (text_byte == CH_NUL) begin
				bundle.res[n[RES_IDX_W-1:0]] = mk_res(KIND_END, 1'b1, CH_NUL, disp_col);
				n = n + 1'b1;
				line_n  = POS_WIDTH'(1);
				col_n   = POS_WIDTH'(1);
				start_n = POS_WIDTH'(1);
			end else if (text_byte == CH_SPACE || text_byte == CH_TAB || text_byte == CH_CR) begin
				col_n = sat_inc(disp_col);
			end else if (text_byte == CH_NL) begin
				line_n = sat_inc(line_q);
				col_n  = POS_WIDTH'(1);
			end else begin
				start_n = disp_col;
				if (text_byte == CH_SLASH) begin
					mode_n = MODE_SLASH;
				end else if (pk_hit) begin
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(pk, 1'b0, text_byte, disp_col);
					n = n + 1'b1;
					bundle.res[n[RES_IDX_W-1:0]] = mk_res(pk, 1'b1, CH_NUL, disp_col);
					n = n + 1'b1;
					col_n = sat_inc(disp_col);
				end else begin
					col_n = sat_inc(disp_col);
					if (text_byte == CH_EQ) begin
						mode_n = MODE_EQ;
					end else if (text_byte == CH_QUOTE) begin
						mode_n = MODE_STR;
					end else if (text_byte == CH_MINUS) begin
						mode_n = MODE_MINUS;
					end else if (is_digit(text_byte)) begin
						bundle.res[n[RES_IDX_W-1:0]] =
							mk_res(KIND_NUMBER, 1'b0, text_byte, disp_col);
						n = n + 1'b1;
						mode_n = MODE_INT;
					end else if (ident_start(text_byte)) begin
						bundle.res[n[RES_IDX_W-1:0]] =
							mk_res(KIND_IDENT, 1'b0, text_byte, disp_col);
						n = n + 1'b1;
						mode_n = MODE_IDENT;
					end else begin
						bundle.res[n[RES_IDX_W-1:0]] =
							mk_res(KIND_BAD_CHAR, 1'b0, text_byte, disp_col);
						n = n + 1'b1;
						bundle.res[n[RES_IDX_W-1:0]] =
							mk_res(KIND_BAD_CHAR, 1'b1, CH_NUL, disp_col);
						n = n + 1'b1;
					end
				end
			end
		end

		bundle.count = n;
	end

	// Advance the scanner state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			line_q  <= POS_WIDTH'(1);
			col_q   <= POS_WIDTH'(1);
			start_q <= POS_WIDTH'(1);
		end else if (take) begin
			mode_q  <= mode_n;
			line_q  <= line_n;
			col_q   <= col_n;
			start_q <= start_n;
		end
	end

endmodule

// File: design/dlsc_emit.sv
// Result register that holds the results of one item and hands them out in order.
module dlsc_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  dlsc_pkg::bundle_t bundle,
	input  logic              out_ready,
	output logic              take_ok,
	input  logic              take,
	output logic              out_valid,
	output dlsc_pkg::res_t    out_res,
	output logic [dlsc_pkg::OUT_POS_W-1:0] out_line,
	output logic              out_last
);
	import dlsc_pkg::*;

	bundle_t              bundle_q;
	logic [RES_CNT_W-1:0] rem_q;
	logic [RES_IDX_W-1:0] idx_q;
	logic                 fire;

	// Present the current result
	assign out_valid = (rem_q != '0);
	assign out_last  = (rem_q == RES_CNT_W'(1));
	assign out_res   = bundle_q.res[idx_q];
	assign out_line  = bundle_q.line;
	assign fire      = out_valid && out_ready;

	// Take a new item once the last held result leaves
	assign take_ok = (rem_q == '0) || (out_last && out_ready);

	// Hold payload of the latest item
	always_ff @(posedge clk) begin
		if (take) begin
			bundle_q <= bundle;
		end
	end

	// Advance through held results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			rem_q <= bundle.count;
			idx_q <= '0;
		end else if (fire) begin
			rem_q <= rem_q - 1'b1;
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

// File: design/dsl_lexical_scanner.sv
// Top level of the streaming lexical scanner.
//
//   channel    dir   handshake      payload
//   text_in    in    valid/ready    text_byte[7:0]
//   token_out  out   valid/ready    token_kind, is_token_end, value_byte,
//                                   token_line, token_column, last_of_run
//
// One text byte is decided in the cycle it is accepted; its zero to four
// results sit in a result register and leave one per cycle while token_out is ready.
// A byte with at most one result keeps one byte per cycle flowing while token_out is
// ready; a byte with more results holds text_in off while the result register drains.
// Reset clears the scanner mode, line and column to their start values.
// token_out stalls hold the current result and block new bytes once it is the last.
module dsl_lexical_scanner #(
	parameter int POS_WIDTH = dlsc_pkg::POS_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dlsc_in_if.sink     text_in,
	dlsc_out_if.source  token_out
);
	import dlsc_pkg::*;

	bundle_t              bundle;
	logic                 take;
	logic                 take_ok;
	res_t                 out_res;
	logic [OUT_POS_W-1:0] out_line;

	assign text_in.ready = take_ok;
	assign take          = text_in.valid && take_ok;

	// Decode each byte against the scanner state
	dlsc_decode #(
		.POS_WIDTH (POS_WIDTH)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.text_byte (text_in.text_byte),
		.bundle    (bundle)
	);

	// Serialize the results
	dlsc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.out_ready (token_out.ready),
		.take_ok   (take_ok),
		.take      (take),
		.out_valid (token_out.valid),
		.out_res   (out_res),
		.out_line  (out_line),
		.out_last  (token_out.last_of_run)
	);

	assign token_out.token_kind   = out_res.kind;
	assign token_out.is_token_end = out_res.is_end;
	assign token_out.value_byte   = out_res.value;
	assign token_out.token_column = out_res.column;
	assign token_out.token_line   = out_line;

endmodule
